[sv/record_sort_rank_average_unit_assert.svh]
// Assertion macros for the record sort, rank and average unit.
// Included by the top level; needs no other file.
`ifndef RECORD_SORT_RANK_AVERAGE_UNIT_ASSERT_SVH
`define RECORD_SORT_RANK_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define RSRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under synchronous reset.
`define RSRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/rsra_pkg.sv]
// Shared constants, types and command codes of the record sort unit.
// No dependencies.
`timescale 1ns / 1ps
package rsra_pkg;
    localparam int MAX_RECORDS = 32;
    localparam int IDX_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W  = 6;
    localparam int SUM_W  = 13;
    localparam int TOT_W  = 10;
    localparam int DIVD_W = 23;
    localparam int DIVS_W = 7;
    localparam int Q_W    = 16;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 120;

    typedef enum logic [1:0] {
        DIV_FIRST,
        DIV_SECOND,
        DIV_THIRD,
        DIV_OVERALL
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     k_clear;
        logic     sort;
        logic     phase;
        logic     div_start;
        t_div_sel div_sel;
        logic     emit_rec;
        logic     emit_sum;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             k_last;
        logic             out_free;
        logic             div_done;
    } t_status;
endpackage

[sv/rsra_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on rsra_pkg.
`timescale 1ns / 1ps
module rsra_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rsra_pkg::DIVD_W-1:0] i_dividend,
    input  logic [rsra_pkg::DIVS_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rsra_pkg::Q_W-1:0]    o_quotient
);
    import rsra_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W:0]   r_rem;
    logic [DIVS_W-1:0] r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   n_trial;
    logic              n_ge;

    always_comb begin
        n_trial = {r_rem[DIVS_W-1:0], r_quo[DIVD_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_step <= STEP_W'(DIVD_W - 1);
            end else if (r_busy) begin
                r_rem <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
                r_quo <= {r_quo[DIVD_W-2:0], n_ge};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[Q_W-1:0];
endmodule

[sv/rsra_datapath.sv]
// Record store, odd-even sort lanes, averaging and output register.
// Depends on rsra_pkg and rsra_divider.
`timescale 1ns / 1ps
module rsra_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsra_pkg::t_cmd             i_cmd,
    output rsra_pkg::t_status          o_status,
    input  logic [rsra_pkg::IN_W-1:0]  i_rec,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [rsra_pkg::OUT_W-1:0] o_m_tdata,
    output logic                       o_m_tuser,
    output logic                       o_m_tlast
);
    import rsra_pkg::*;

    logic [IN_W-1:0]  r_rec [MAX_RECORDS];
    logic [TOT_W-1:0] r_tot [MAX_RECORDS];
    logic [SUM_W-1:0] r_sum [3];
    logic [Q_W-1:0]   r_mean [4];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_k;
    t_div_sel         r_div_sel;
    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;
    logic             r_olast;

    logic [TOT_W-1:0]  n_new_tot;
    logic [TOT_W-1:0]  n_k_tot;
    logic [20:0]       n_p3;
    logic [Q_W-1:0]    n_rmean;
    logic [IN_W-1:0]   n_k_rec;
    logic [14:0]       n_all;
    logic [DIVD_W-1:0] n_dividend;
    logic [DIVS_W-1:0] n_divisor;
    logic [7:0]        n_n3;
    logic              n_div_done;
    logic [Q_W-1:0]    n_quo;
    logic              n_free;

    assign n_new_tot = TOT_W'(i_rec[23:16]) + TOT_W'(i_rec[15:8]) + TOT_W'(i_rec[7:0]);
    assign n_k_rec   = r_rec[r_k[IDX_W-1:0]];
    assign n_k_tot   = r_tot[r_k[IDX_W-1:0]];
    // floor(t*256/3) = 85*t + floor(t/3); t/3 via reciprocal 683/2048
    assign n_p3      = 21'(n_k_tot) * 21'd683;
    assign n_rmean   = 16'(n_k_tot) * 16'd85 + 16'(n_p3[20:11]);
    assign n_all     = 15'(r_sum[0]) + 15'(r_sum[1]) + 15'(r_sum[2]);
    assign n_n3      = 8'(r_cnt) + {1'b0, r_cnt, 1'b0};
    assign n_free    = !r_ovalid || i_m_tready;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_FIRST:  n_dividend = {2'b0, r_sum[0], 8'b0};
            DIV_SECOND: n_dividend = {2'b0, r_sum[1], 8'b0};
            DIV_THIRD:  n_dividend = {2'b0, r_sum[2], 8'b0};
            default:    n_dividend = {n_all, 8'b0};
        endcase
        n_divisor = (i_cmd.div_sel == DIV_OVERALL) ? n_n3[DIVS_W-1:0]
                                                    : DIVS_W'(r_cnt);
    end

    rsra_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (n_div_done),
        .o_quotient (n_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            for (int c = 0; c < 3; c++) r_sum[c] <= '0;
        end else begin
            if (i_cmd.load && r_cnt < CNT_W'(MAX_RECORDS)) begin
                r_rec[r_cnt[IDX_W-1:0]] <= i_rec;
                r_tot[r_cnt[IDX_W-1:0]] <= n_new_tot;
                r_sum[0] <= r_sum[0] + SUM_W'(i_rec[23:16]);
                r_sum[1] <= r_sum[1] + SUM_W'(i_rec[15:8]);
                r_sum[2] <= r_sum[2] + SUM_W'(i_rec[7:0]);
                r_cnt    <= r_cnt + 1'b1;
            end
            if (i_cmd.sort) begin
                for (int j = 0; j < MAX_RECORDS - 1; j++) begin
                    if (1'(j) == i_cmd.phase && CNT_W'(j + 1) < r_cnt &&
                        r_tot[j] < r_tot[j+1]) begin
                        r_rec[j]   <= r_rec[j+1];
                        r_rec[j+1] <= r_rec[j];
                        r_tot[j]   <= r_tot[j+1];
                        r_tot[j+1] <= r_tot[j];
                    end
                end
            end
            if (i_cmd.div_start) r_div_sel <= i_cmd.div_sel;
            if (n_div_done) r_mean[r_div_sel] <= n_quo;
            if (i_cmd.k_clear) r_k <= '0;
            else if (i_cmd.emit_rec) r_k <= r_k + 1'b1;
            if (i_cmd.emit_rec || i_cmd.emit_sum) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
            if (i_cmd.emit_sum) begin
                r_cnt <= '0;
                for (int c = 0; c < 3; c++) r_sum[c] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rec) begin
            r_odata <= {66'b0, 6'(r_k + 1'b1), n_rmean,
                        n_k_rec[7:0], n_k_rec[15:8], n_k_rec[23:16], n_k_rec[31:24]};
            r_olast <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            r_odata <= {2'b0, r_mean[3], r_mean[2], r_mean[1], r_mean[0], 54'b0};
            r_olast <= 1'b1;
        end
    end

    assign o_status.cnt      = r_cnt;
    assign o_status.k_last   = (r_k == r_cnt - 1'b1);
    assign o_status.out_free = n_free;
    assign o_status.div_done = n_div_done;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_olast;
    assign o_m_tlast  = r_olast;
endmodule

[sv/rsra_controller.sv]
// Sequencer: load, sort passes, divisions, emission of results.
// Depends on rsra_pkg.
`timescale 1ns / 1ps
module rsra_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tlast,
    output logic              o_s_tready,
    input  rsra_pkg::t_status i_status,
    output rsra_pkg::t_cmd    o_cmd
);
    import rsra_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_SUMMARY
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_pass;
    t_div_sel         r_sel;
    logic             n_acc;

    assign o_s_tready = (r_state == ST_LOAD);
    assign n_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.div_sel   = r_sel;
        o_cmd.phase     = r_pass[0];
        o_cmd.load      = n_acc;
        o_cmd.k_clear   = n_acc && i_s_tlast;
        o_cmd.sort      = (r_state == ST_SORT);
        o_cmd.div_start = (r_state == ST_DIV_START);
        o_cmd.emit_rec  = (r_state == ST_EMIT) && i_status.out_free;
        o_cmd.emit_sum  = (r_state == ST_SUMMARY) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_pass  <= '0;
            r_sel   <= DIV_FIRST;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (n_acc && i_s_tlast) begin
                        r_state <= ST_SORT;
                        r_pass  <= '0;
                    end
                end
                ST_SORT: begin
                    r_pass <= r_pass + 1'b1;
                    if (r_pass == i_status.cnt - 1'b1) begin
                        r_state <= ST_DIV_START;
                        r_sel   <= DIV_FIRST;
                    end
                end
                ST_DIV_START: r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (i_status.div_done) begin
                        if (r_sel == DIV_OVERALL) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_sel   <= t_div_sel'(r_sel + 1'b1);
                            r_state <= ST_DIV_START;
                        end
                    end
                end
                ST_EMIT: begin
                    if (i_status.out_free && i_status.k_last) r_state <= ST_SUMMARY;
                end
                ST_SUMMARY: begin
                    if (i_status.out_free) r_state <= ST_LOAD;
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end
endmodule

[sv/record_sort_rank_average_unit.sv]
// Load phase: one record transfer per cycle, no results until the last record.
// After the last record: n odd-even sort passes (n records), then four serial
// divisions, then n record results and one summary at one per cycle while the
// output side takes them.
// Reset (i_rst_n low, synchronous) empties the store and clears the sums.
`timescale 1ns / 1ps
module record_sort_rank_average_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [7:0] record_tag, [15:8] score_first, [23:16] score_second, [31:24] score_third
    input  logic [rsra_pkg::IN_W-1:0]   i_s_tdata,
    input  logic                        i_s_tlast,     // final_record
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [7:0] out_tag, [15:8] out_first, [23:16] out_second, [31:24] out_third,
    // [47:32] record_mean, [53:48] position_rank, [69:54] mean_first,
    // [85:70] mean_second, [101:86] mean_third, [117:102] mean_overall
    output logic [rsra_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                        o_m_tuser,     // is_summary
    output logic                        o_m_tlast      // end_of_run
);
    import rsra_pkg::*;
`include "record_sort_rank_average_unit_assert.svh"

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_s_tready;

    // Controller sequences the phases; the datapath holds all records and sums.
    rsra_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (w_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Store records with the sum in the store byte order: tag high, third low.
    rsra_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_rec      ({i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16], i_s_tdata[31:24]}),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready = w_s_tready;

    // Hold input off (tready low) after the closing record until the run has been emitted.
    `RSRA_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready)
    // The summary is the only item that ends a run.
    `RSRA_ASSERT_NOW(a_last_is_summary, i_clk, i_rst_n, o_m_tvalid, o_m_tlast == o_m_tuser)
    // Every record result carries a nonzero rank.
    `RSRA_ASSERT_NOW(a_rank_nonzero, i_clk, i_rst_n,
        o_m_tvalid && !o_m_tuser, o_m_tdata[53:48] != 6'd0)
endmodule
